FILE: hw/rtl/assert_macros.svh
// assertion helpers included by the band attenuation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/sba_pkg.sv
package sba_pkg;

  // fixed field widths
  localparam int POS_W = 18;
  localparam int LVL_W = 17;
  localparam int PNT_W = 21;
  localparam int IDX_W = 3;
  localparam int TDATA_W = 24;

  // default fraction bits
  localparam int FRAC_BITS_DEF = 16;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CENTRE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HALF    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RAMP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INSIDE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTSIDE = 3'd4;

  // register reset values
  localparam logic signed [POS_W-1:0] CENTRE_RST  = 18'sd65536;
  localparam logic [POS_W-1:0]        HALF_RST    = 18'd0;
  localparam logic [POS_W-1:0]        RAMP_RST    = 18'd65536;
  localparam logic [LVL_W-1:0]        INSIDE_RST  = 17'd65536;
  localparam logic [LVL_W-1:0]        OUTSIDE_RST = 17'd0;

  // where a sample falls relative to the four breakpoints
  typedef enum logic [1:0] {
    RG_OUT,
    RG_RISE,
    RG_IN,
    RG_FALL
  } region_t;

endpackage

FILE: hw/rtl/smoothstep_band_attenuation.sv
// Smoothstep band attenuation: maps one signed normal component to an
// attenuation level through a trapezoid window with smoothstep ramps.
// Channels: in_ stream carries normal_component, out_ stream carries
// attenuation, cfg_ writes one of five registers (centre, plateau half
// width, ramp width, inside level, outside level); cfg_ready is always high.
// Throughput: one item per clock while the skid register is empty. The divide
// of the ramp distance by the ramp width is a pipelined restoring divider, one
// quotient bit per stage, followed by three multiply stages and a final add.
// Pipeline order: stage a, stage b, the divider stages, stages m1, m2 and m3,
// then the output register.
// Reset: synchronous active-low rst_n empties the pipeline and the output
// skid register and loads the register reset values.
// Stall: when out_tready is low the pending result moves into a skid register
// and the pipeline still advances in that cycle; with the skid register full
// the whole pipeline holds and in_tready drops. Nothing is dropped or repeated.
// The user must write registers only while no item is in flight; not enforced.
`include "assert_macros.svh"

module smoothstep_band_attenuation
  import sba_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [17:0] normal_component
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [16:0] attenuation
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [POS_W-1:0]   cfg_data
);

  localparam int F      = FRAC_BITS;
  localparam int NW     = POS_W + F + 1;
  localparam int ST_B   = 1;
  localparam int ST_D0  = 2;
  localparam int ST_M1  = F + 3;
  localparam int ST_M2  = F + 4;
  localparam int ST_M3  = F + 5;
  localparam int ST_O   = F + 6;
  localparam int NST    = F + 7;
  localparam int unsigned HALF = 2 ** (F - 1);
  localparam logic [F:0]   ONE       = (F + 1)'(2 ** F);
  localparam logic [F+1:0] THREE_ONE = (F + 2)'(3 * (2 ** F));

  // configuration registers
  logic signed [POS_W-1:0] centre_r;
  logic [POS_W-1:0]        half_r;
  logic [POS_W-1:0]        ramp_r;
  logic [LVL_W-1:0]        inside_r;
  logic [LVL_W-1:0]        outside_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r  <= CENTRE_RST;
      half_r    <= HALF_RST;
      ramp_r    <= RAMP_RST;
      inside_r  <= INSIDE_RST;
      outside_r <= OUTSIDE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTRE:  centre_r  <= cfg_data;
        REG_HALF:    half_r    <= cfg_data;
        REG_RAMP:    ramp_r    <= cfg_data;
        REG_INSIDE:  inside_r  <= cfg_data[LVL_W-1:0];
        REG_OUTSIDE: outside_r <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move together while the skid register is free
  logic             en;
  logic [NST-1:0]   vld_r;
  logic             skid_full_r;
  logic [LVL_W-1:0] skid_att_r;
  logic [LVL_W-1:0] o_att_r;

  assign en        = !skid_full_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // breakpoints, exact in 21 bits
  logic signed [PNT_W-1:0] c_x, s_x, r_x, v_x;
  logic signed [PNT_W-1:0] p1, p2, p3, p4;
  logic signed [PNT_W-1:0] d_rise, d_fall;

  assign c_x = {{(PNT_W - POS_W){centre_r[POS_W-1]}}, centre_r};
  assign s_x = {{(PNT_W - POS_W){1'b0}}, half_r};
  assign r_x = {{(PNT_W - POS_W){1'b0}}, ramp_r};
  assign v_x = {{(PNT_W - POS_W){in_tdata[POS_W-1]}}, in_tdata[POS_W-1:0]};
  assign p2  = c_x - s_x;
  assign p1  = p2 - r_x;
  assign p3  = c_x + s_x;
  assign p4  = p3 + r_x;
  assign d_rise = v_x - p1;
  assign d_fall = v_x - p3;

  // stage a: classify the sample and take its distance into the ramp
  region_t          rg_a;
  logic [POS_W-1:0] d_a;
  region_t          rg_r [ST_M3+1];
  logic [POS_W-1:0] d_a_r;

  always_comb begin
    rg_a = RG_OUT;
    d_a  = d_rise[POS_W-1:0];
    if (v_x <= p1) begin
      rg_a = RG_OUT;
    end else if (v_x <= p2) begin
      rg_a = RG_RISE;
    end else if (v_x <= p3) begin
      rg_a = RG_IN;
    end else if (v_x <= p4) begin
      rg_a = RG_FALL;
      d_a  = d_fall[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg_r[0] <= rg_a;
      d_a_r   <= d_a;
      for (int k = 1; k <= ST_M3; k++) begin
        rg_r[k] <= rg_r[k-1];
      end
    end
  end

  // stage b: dividend d * 2^F + r/2, split into first remainder and low bits
  logic [NW-1:0]    num_b;
  logic [POS_W-1:0] rem_b_r;
  logic [F:0]       qn_b_r;

  assign num_b = {1'b0, d_a_r, {F{1'b0}}} + NW'(ramp_r >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_b_r <= num_b[NW-1:F+1];
      qn_b_r  <= num_b[F:0];
    end
  end

  // divider: one quotient bit per stage, dividend bits shift out as quotient shifts in
  logic [POS_W-1:0] rem_in [F+1];
  logic [F:0]       qn_in  [F+1];
  logic [POS_W-1:0] rem_r  [F+1];
  logic [F:0]       qn_r   [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic [POS_W:0] trial;
    logic [POS_W:0] diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in[j] = rem_b_r;
      assign qn_in[j]  = qn_b_r;
    end else begin : g_next
      assign rem_in[j] = rem_r[j-1];
      assign qn_in[j]  = qn_r[j-1];
    end

    assign trial = {rem_in[j], qn_in[j][F]};
    assign diff  = trial - {1'b0, ramp_r};
    assign ge    = trial >= {1'b0, ramp_r};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
        qn_r[j]  <= {qn_in[j][F-1:0], ge};
      end
    end
  end

  // stage m1: u squared and the 3 - 2u factor
  logic [F:0]       uq;
  logic [2*F+1:0]   sq_full;
  logic [F:0]       sq_r;
  logic [F+1:0]     t_r;

  assign uq      = qn_r[F];
  assign sq_full = {{(F + 1){1'b0}}, uq} * {{(F + 1){1'b0}}, uq} + (2 * F + 2)'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_full[2*F:F];
      t_r  <= THREE_ONE - {uq, 1'b0};
    end
  end

  // stage m2: smoothstep weight, clamped to one
  logic [2*F+2:0] h_full;
  logic [F+2:0]   h_raw;
  logic [F:0]     h_r;

  assign h_full = {{(F + 2){1'b0}}, sq_r} * {{(F + 1){1'b0}}, t_r} + (2 * F + 3)'(HALF);
  assign h_raw  = h_full[2*F+2:F];

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= (h_raw > (F + 3)'(ONE)) ? ONE : h_raw[F:0];
    end
  end

  // stage m3: pick start and end levels, scale their gap by the weight
  logic [LVL_W-1:0]   lv_a, lv_b, dif;
  logic [F:0]         hw;
  logic               up;
  logic [LVL_W+F:0]   prod;
  logic [LVL_W-1:0]   a_r;
  logic [LVL_W-1:0]   delta_r;
  logic               up_r;

  always_comb begin
    lv_a = outside_r;
    lv_b = outside_r;
    hw   = '0;
    case (rg_r[ST_M2])
      RG_RISE: begin
        lv_a = outside_r;
        lv_b = inside_r;
        hw   = h_r;
      end
      RG_IN: begin
        lv_a = inside_r;
        lv_b = inside_r;
      end
      RG_FALL: begin
        lv_a = inside_r;
        lv_b = outside_r;
        hw   = h_r;
      end
      default: begin
        lv_a = outside_r;
        lv_b = outside_r;
      end
    endcase
    up   = lv_b >= lv_a;
    dif  = up ? (lv_b - lv_a) : (lv_a - lv_b);
    prod = {{(F + 1){1'b0}}, dif} * {{LVL_W{1'b0}}, hw} + (LVL_W + F + 1)'(HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= lv_a;
      delta_r <= prod[LVL_W+F-1:F];
      up_r    <= up;
    end
  end

  // output stage: move the start level by the rounded step
  always_ff @(posedge clk) begin
    if (en) begin
      o_att_r <= up_r ? (a_r + delta_r) : (a_r - delta_r);
    end
  end

  // skid register catches the result that the receiver did not take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_tready) begin
        skid_full_r <= 1'b0;
      end
    end else if (vld_r[ST_O] && !out_tready) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_att_r <= o_att_r;
    end
  end

  assign out_tvalid = skid_full_r || vld_r[ST_O];
  assign out_tdata  = {{(TDATA_W - LVL_W){1'b0}}, (skid_full_r ? skid_att_r : o_att_r)};

  // checks
  `SBA_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (vld_r == '0) && !skid_full_r, "reset left items in flight")
  `SBA_ASSERT(a_flat_no_step, vld_r[ST_M3] && (rg_r[ST_M3] == RG_OUT || rg_r[ST_M3] == RG_IN) |-> delta_r == '0, "flat region got a ramp step")
  `SBA_ASSERT(a_skid_holds, skid_full_r && !out_tready |=> skid_full_r && $stable(skid_att_r), "skid result lost while stalled")
  `SBA_ASSERT(a_skid_source, $rose(skid_full_r) |-> $past(vld_r[ST_O] && !out_tready), "skid filled without a stalled result")

endmodule

FILE: verif/band_attenuation_checker.sv
module band_attenuation_checker
  import sba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [17:0] normal_component
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,  // [16:0] attenuation
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [POS_W-1:0]   cfg_data,
  output int                 in_flight,
  output int                 mismatch_count
);

  localparam int     FRAC = FRAC_BITS_DEF;
  localparam longint ONE  = longint'(1) << FRAC;
  localparam longint HALF = ONE >>> 1;

  // shadow copy of the band registers
  logic signed [POS_W-1:0] centre;
  logic [POS_W-1:0]        half_width;
  logic [POS_W-1:0]        ramp;
  logic [LVL_W-1:0]        inside_lvl;
  logic [LVL_W-1:0]        outside;

  // attenuation values still owed by the block, oldest first
  logic [LVL_W-1:0] pending_attenuation [$];

  // smoothstep weight u*u*(3-2u) in fixed point, distance d into a ramp of width r
  function automatic longint ramp_weight(input longint d, input longint r);
    longint uq, sq, h;
    if (r == 0) return ONE;
    if (d > r) d = r;
    uq = ((d <<< FRAC) + (r >>> 1)) / r;
    if (uq > ONE) uq = ONE;
    sq = (uq * uq + HALF) >>> FRAC;
    h  = (sq * (3 * ONE - 2 * uq) + HALF) >>> FRAC;
    if (h > ONE) h = ONE;
    return h;
  endfunction

  // move level a toward b by weight h, rounding half away from zero
  function automatic longint blend_level(input longint a, input longint b, input longint h);
    if (b >= a) return a + (((b - a) * h + HALF) >>> FRAC);
    return a - (((a - b) * h + HALF) >>> FRAC);
  endfunction

  function automatic logic [LVL_W-1:0] band_attenuation(input longint v);
    longint  c, s, r, lvl_in, lvl_out, lvl;
    region_t zone;
    c       = centre;
    s       = half_width;
    r       = ramp;
    lvl_in  = inside_lvl;
    lvl_out = outside;
    // breakpoints are exact in 64 bits, nothing wraps
    if (v <= c - s - r) zone = RG_OUT;
    else if (v <= c - s) zone = RG_RISE;
    else if (v <= c + s) zone = RG_IN;
    else if (v <= c + s + r) zone = RG_FALL;
    else zone = RG_OUT;
    case (zone)
      RG_RISE: lvl = blend_level(lvl_out, lvl_in, ramp_weight(v - (c - s - r), r));
      RG_IN:   lvl = lvl_in;
      RG_FALL: lvl = blend_level(lvl_in, lvl_out, ramp_weight(v - (c + s), r));
      default: lvl = lvl_out;
    endcase
    return lvl[LVL_W-1:0];
  endfunction

  // watch all three channels
  always @(posedge clk) begin
    logic [LVL_W-1:0] want;
    if (!rst_n) begin
      centre         = CENTRE_RST;
      half_width     = HALF_RST;
      ramp           = RAMP_RST;
      inside_lvl     = INSIDE_RST;
      outside        = OUTSIDE_RST;
      mismatch_count = 0;
      pending_attenuation.delete();
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (pending_attenuation.size() == 0) begin
          $error("attenuation: nothing expected, got %0d", out_tdata[LVL_W-1:0]);
          mismatch_count++;
        end else begin
          want = pending_attenuation.pop_front();
          if (out_tdata[LVL_W-1:0] !== want) begin
            $error("attenuation: expected %0d, got %0d", want, out_tdata[LVL_W-1:0]);
            mismatch_count++;
          end
          if (out_tdata[TDATA_W-1:LVL_W] !== '0) begin
            $error("out_tdata padding: expected 0, got %0h", out_tdata[TDATA_W-1:LVL_W]);
            mismatch_count++;
          end
        end
      end
      // input transfer: predict with the current registers
      if (in_tvalid && in_tready)
        pending_attenuation.insert(pending_attenuation.size(),
                                   band_attenuation($signed(in_tdata[POS_W-1:0])));
      // register write, unknown indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTRE:  centre     = cfg_data;
          REG_HALF:    half_width = cfg_data;
          REG_RAMP:    ramp       = cfg_data;
          REG_INSIDE:  inside_lvl = cfg_data[LVL_W-1:0];
          REG_OUTSIDE: outside    = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
    end
    in_flight = pending_attenuation.size();
  end

endmodule

FILE: verif/smoothstep_band_attenuation_tb.sv
module smoothstep_band_attenuation_tb;
  import sba_pkg::*;

  localparam int     DRAIN_CYCLES  = FRAC_BITS_DEF + 12;
  localparam int     LONG_HOLD     = 300;
  localparam int     RANDOM_PHASES = 17;
  localparam int     PHASE_ITEMS   = 100;
  localparam longint POS_MIN       = -131072;
  localparam longint POS_MAX       = 131071;
  // indexes past the last register
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // [17:0] normal_component
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // [16:0] attenuation
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [POS_W-1:0]   cfg_data;

  int     in_flight;
  int     mismatch_count;
  bit     steady;
  bit     long_hold_req;
  bit     long_hold_done;
  // band geometry as last written, used to aim samples
  longint band_c, band_s, band_r;

  smoothstep_band_attenuation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  band_attenuation_checker band_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_flight      (in_flight),
    .mismatch_count (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_cycles();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp_pos(input longint x);
    if (x < POS_MIN) return POS_MIN;
    if (x > POS_MAX) return POS_MAX;
    return x;
  endfunction

  function automatic logic [LVL_W-1:0] random_level();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 20) return 17'd65536;
    if (sel < 85) return LVL_W'($urandom_range(0, 65536));
    return LVL_W'($urandom);
  endfunction

  // sample aimed at the breakpoints and ramps of the current band
  function automatic longint aimed_sample();
    longint     pts [4];
    longint     d;
    int         sel;
    int         off;
    logic [31:0] raw;
    pts[0] = band_c - band_s - band_r;
    pts[1] = band_c - band_s;
    pts[2] = band_c + band_s;
    pts[3] = band_c + band_s + band_r;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      raw = $urandom;
      return $signed(raw[POS_W-1:0]);
    end
    if (sel < 40) begin
      off = $urandom_range(0, 8);
      return clamp_pos(pts[2'($urandom_range(0, 3))] + off - 4);
    end
    if (sel < 85 && band_r > 0) begin
      d = $urandom_range(1, 32'(band_r));
      return clamp_pos(($urandom_range(0, 1) ? pts[0] : pts[2]) + d);
    end
    off = $urandom_range(0, 131072);
    return off - 65536;
  endfunction

  // one input transfer, entered and left just after a falling edge
  task automatic send_sample(input longint v);
    int               gap;
    logic [POS_W-1:0] bits;
    bits = v[POS_W-1:0];
    gap  = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-POS_W){1'b0}}, bits};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // one register transfer; the caller lowers cfg_valid after the batch
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_CENTRE: band_c = $signed(value);
      REG_HALF:   band_s = value;
      REG_RAMP:   band_r = value;
      default: ;
    endcase
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // stop offering and let the pipeline drain before touching registers
  task automatic end_phase();
    in_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic randomize_band();
    logic [POS_W-1:0] value;
    int               sel;
    if ($urandom_range(0, 3) != 0) begin
      sel   = $urandom_range(0, 99);
      value = (sel < 80) ? POS_W'($urandom_range(0, 131072) - 65536) : POS_W'($urandom);
      write_reg(REG_CENTRE, value);
    end
    if ($urandom_range(0, 3) != 0) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) value = '0;
      else if (sel < 70) value = POS_W'($urandom_range(0, 16384));
      else if (sel < 90) value = POS_W'($urandom_range(0, 131072));
      else value = POS_W'($urandom);
      write_reg(REG_HALF, value);
    end
    if ($urandom_range(0, 3) != 0) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) value = '0;
      else if (sel < 30) value = POS_W'($urandom_range(1, 16));
      else if (sel < 80) value = POS_W'($urandom_range(1, 65536));
      else if (sel < 90) value = POS_W'($urandom_range(1, 131072));
      else value = POS_W'($urandom);
      write_reg(REG_RAMP, value);
    end
    // level writes sometimes carry junk above bit 16
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_INSIDE,
                ($urandom_range(0, 5) == 0) ? POS_W'($urandom) : POS_W'(random_level()));
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_OUTSIDE,
                ($urandom_range(0, 5) == 0) ? POS_W'($urandom) : POS_W'(random_level()));
    if ($urandom_range(0, 7) == 0)
      write_reg(IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), POS_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure plus one long hold
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_cycles()) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #8000000;
    $display("smoothstep_band_attenuation regression: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_CENTRE;
    cfg_data       = '0;
    steady         = 1'b0;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    band_c         = CENTRE_RST;
    band_s         = HALF_RST;
    band_r         = RAMP_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset band: ramp 0..1, plateau a single point at one, field extremes
    send_sample(0);
    send_sample(1);
    send_sample(32768);
    send_sample(65535);
    send_sample(65536);
    send_sample(65537);
    send_sample(98304);
    send_sample(131071);
    send_sample(-131072);
    send_sample(-1);
    send_sample(-65536);
    send_sample(131070);
    end_phase();

    // hard edges with zero ramp width
    write_reg(REG_CENTRE, 18'd0);
    write_reg(REG_HALF, 18'd16384);
    write_reg(REG_RAMP, 18'd0);
    write_reg(REG_INSIDE, 18'd65536);
    write_reg(REG_OUTSIDE, 18'd0);
    cfg_valid <= 1'b0;
    send_sample(-16385);
    send_sample(-16384);
    send_sample(-16383);
    send_sample(16384);
    send_sample(16385);
    end_phase();

    // inside below outside, ramps run downward
    write_reg(REG_CENTRE, -18'sd65536);
    write_reg(REG_HALF, 18'd0);
    write_reg(REG_RAMP, 18'd131072);
    write_reg(REG_INSIDE, 18'd0);
    write_reg(REG_OUTSIDE, 18'd65536);
    cfg_valid <= 1'b0;
    send_sample(-131072);
    send_sample(-65537);
    send_sample(-65536);
    send_sample(0);
    send_sample(65536);
    end_phase();

    // every register at its field extreme, plus an unknown index
    write_reg(REG_CENTRE, 18'h20000);
    write_reg(REG_HALF, 18'h3FFFF);
    write_reg(REG_RAMP, 18'h3FFFF);
    write_reg(REG_INSIDE, 18'h1FFFF);
    write_reg(REG_OUTSIDE, 18'd0);
    write_reg(REG_SPARE_LO, 18'h3FFFF);
    cfg_valid <= 1'b0;
    send_sample(-131072);
    send_sample(131071);
    send_sample(0);
    end_phase();

    // random bands with aimed samples
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_band();
      steady = (ph == 2) || ($urandom_range(0, 4) == 0);
      if (ph == 2) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_sample(aimed_sample());
      end_phase();
    end

    if (mismatch_count == 0) begin
      $display("smoothstep_band_attenuation regression: pass");
    end else begin
      $display("smoothstep_band_attenuation regression: fail");
    end
    $finish;
  end

endmodule
